// ===== hdl/srld_pkg.sv =====
// shared types and constants for the subpicture run-length line decoder
// used by every module of the block; depends on nothing

package srld_pkg;

   // widths and limits
   localparam int unsigned WIDTH_W        = 13;
   localparam int unsigned LINES_W        = 12;
   localparam int unsigned WORD_W         = 32;
   localparam int unsigned ACC_W          = 12;
   localparam int unsigned CODE_W         = 16;
   localparam int unsigned ADDR_W         = 5;
   localparam int unsigned QUEUE_DEPTH    = 2;
   localparam logic [WIDTH_W-1:0] MAX_LINE_WIDTH = 13'd4096;

   // thresholds at which a code of 1, 2 or 3 nibbles is complete
   localparam logic [CODE_W-1:0] CODE_MIN_1 = 16'h0004;
   localparam logic [CODE_W-1:0] CODE_MIN_2 = 16'h0010;
   localparam logic [CODE_W-1:0] CODE_MIN_3 = 16'h0040;
   localparam logic [3:0]        NIB_MIN    = 4'h4;

   // register word indexes
   localparam logic [2:0] REG_LINE_WIDTH = 3'd0;
   localparam logic [2:0] REG_MAX_LINES  = 3'd1;
   localparam logic [2:0] REG_PALETTE_0  = 3'd2;
   localparam logic [2:0] REG_PALETTE_1  = 3'd3;
   localparam logic [2:0] REG_PALETTE_2  = 3'd4;
   localparam logic [2:0] REG_PALETTE_3  = 3'd5;

   // register reset values
   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd720;
   localparam logic [LINES_W-1:0] MAX_LINES_RESET  = 12'd288;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       field_last;
   } req_type;

   typedef struct packed {
      logic [1:0]         color_index;
      logic [WORD_W-1:0]  pixel_value;
      logic [WIDTH_W-1:0] run_length;
      logic               line_end;
      logic               field_full;
      logic               last_of_byte;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]     line_width;
      logic [LINES_W-1:0]     max_lines;
      logic [3:0][WORD_W-1:0] palette;
   } cfg_type;

endpackage

// ===== hdl/srld_csr.sv =====
// configuration registers of the run-length line decoder, apb-style port
// depends on srld_pkg

module srld_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [srld_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [srld_pkg::WORD_W-1:0]   csr_pwdata,
   output logic [srld_pkg::WORD_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output srld_pkg::cfg_type             cfg
);
   import srld_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width <= LINE_WIDTH_RESET;
         cfg_ff.max_lines  <= MAX_LINES_RESET;
         cfg_ff.palette    <= '0;
      end else if (wr_en) begin
         case (index)
            REG_LINE_WIDTH: cfg_ff.line_width <= csr_pwdata[WIDTH_W-1:0];
            REG_MAX_LINES:  cfg_ff.max_lines  <= csr_pwdata[LINES_W-1:0];
            REG_PALETTE_0:  cfg_ff.palette[0] <= csr_pwdata;
            REG_PALETTE_1:  cfg_ff.palette[1] <= csr_pwdata;
            REG_PALETTE_2:  cfg_ff.palette[2] <= csr_pwdata;
            REG_PALETTE_3:  cfg_ff.palette[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (index)
         REG_LINE_WIDTH: csr_prdata = {{(WORD_W-WIDTH_W){1'b0}}, cfg_ff.line_width};
         REG_MAX_LINES:  csr_prdata = {{(WORD_W-LINES_W){1'b0}}, cfg_ff.max_lines};
         REG_PALETTE_0:  csr_prdata = cfg_ff.palette[0];
         REG_PALETTE_1:  csr_prdata = cfg_ff.palette[1];
         REG_PALETTE_2:  csr_prdata = cfg_ff.palette[2];
         REG_PALETTE_3:  csr_prdata = cfg_ff.palette[3];
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== hdl/srld_front.sv =====
// front end: accepts data bytes and holds them in a two-entry queue
// depends on srld_pkg

module srld_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srld_pkg::req_type req_data,
   input  logic              head_pop,
   output logic              head_valid,
   output srld_pkg::req_type head_data
);
   import srld_pkg::*;

   req_type    entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_ready  = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_pop && head_valid;
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ===== hdl/srld_back.sv =====
// back end: decodes one nibble a cycle unless a run finds the result register full,
// tracks line state, drives the result register; depends on srld_pkg

module srld_back (
   input  logic              clock,
   input  logic              reset,
   input  srld_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  srld_pkg::req_type head_data,
   output logic              head_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srld_pkg::rsp_type rsp_data
);
   import srld_pkg::*;

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [1:0]         held_ff, held_in;
   logic [WIDTH_W-1:0] pos_ff, pos_in;
   logic [LINES_W-1:0] count_ff, count_in;
   logic               done_ff, done_in;
   logic               phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [3:0]         nib;
   logic [CODE_W-1:0]  code;
   logic               code_done;
   logic [WIDTH_W-1:0] width;
   logic [WIDTH_W-1:0] remain;
   logic [CODE_W-3:0]  len_raw;
   logic               lend;
   logic [WIDTH_W-1:0] len;
   logic [LINES_W-1:0] count_next;
   logic               full;
   logic               out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // code assembly for the current nibble
   always_comb begin
      nib  = phase_ff ? head_data.code_byte[3:0] : head_data.code_byte[7:4];
      code = {acc_ff, nib};
      case (held_ff)
         2'd0:    code_done = (code >= CODE_MIN_1);
         2'd1:    code_done = (code >= CODE_MIN_2);
         2'd2:    code_done = (code >= CODE_MIN_3);
         default: code_done = 1'b1;
      endcase
   end

   // run clipping against the line
   always_comb begin
      width      = (cfg.line_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : cfg.line_width;
      remain     = (width > pos_ff) ? (width - pos_ff) : '0;
      len_raw    = code[CODE_W-1:2];
      lend       = (len_raw == '0) || ({1'b0, remain} <= len_raw);
      len        = lend ? remain : len_raw[WIDTH_W-1:0];
      count_next = count_ff + 12'd1;
      full       = lend && (count_next >= cfg.max_lines);
   end

   // one nibble per cycle, stalls only when a run finds the result register full
   always_comb begin
      acc_in       = acc_ff;
      held_in      = held_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      phase_in     = phase_ff;
      rsp_data_in  = rsp_data_ff;
      head_pop     = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (head_valid) begin
         if (done_ff) begin
            head_pop = 1'b1;
         end else if (!code_done) begin
            acc_in  = code[ACC_W-1:0];
            held_in = held_ff + 2'd1;
            if (phase_ff) begin
               head_pop = 1'b1;
            end else begin
               phase_in = 1'b1;
            end
         end else if (out_free) begin
            acc_in                   = '0;
            held_in                  = '0;
            pos_in                   = lend ? '0 : (pos_ff + len_raw[WIDTH_W-1:0]);
            count_in                 = lend ? count_next : count_ff;
            done_in                  = full;
            rsp_valid_in             = 1'b1;
            rsp_data_in.color_index  = code[1:0];
            rsp_data_in.pixel_value  = cfg.palette[code[1:0]];
            rsp_data_in.run_length   = len;
            rsp_data_in.line_end     = lend;
            rsp_data_in.field_full   = full;
            rsp_data_in.last_of_byte = lend || phase_ff
                                       || (head_data.code_byte[3:0] < NIB_MIN);
            if (lend || phase_ff) begin
               head_pop = 1'b1;
            end else begin
               phase_in = 1'b1;
            end
         end
         // byte finished: next byte starts on its high nibble, field end clears state
         if (head_pop) begin
            phase_in = 1'b0;
            if (head_data.field_last) begin
               acc_in   = '0;
               held_in  = '0;
               pos_in   = '0;
               count_in = '0;
               done_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/subpicture_rle_line_decoder.sv =====
// top level of the subpicture run-length line decoder
// depends on srld_pkg, srld_csr, srld_front, srld_back
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_ready   req_type: code_byte, field_last
//   rsp_      out         rsp_valid/rsp_ready   rsp_type: one decoded run
//   csr_      in          apb setup + access    six 32-bit registers at 4*i
//
// the back end decodes one nibble per cycle unless a run finds the register full;
// a byte ends at its high nibble when it ends a line or the field is already full.
// a two-entry input queue takes the next byte while the current one decodes;
// one result register feeds rsp_ and a run waits there only while rsp_ready is low.
// synchronous reset clears all decode state and loads the register defaults.

module subpicture_rle_line_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  srld_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output srld_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [srld_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [srld_pkg::WORD_W-1:0]   csr_pwdata,
   output logic [srld_pkg::WORD_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import srld_pkg::*;

   cfg_type cfg;
   logic    head_valid;
   req_type head_data;
   logic    head_pop;

   // register file
   srld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input queue
   srld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .head_pop   (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // nibble decoder and result register
   srld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
